FILE: rtl/gcw_pkg.sv
// ----------------------------------------------------------------------------
// gcw_pkg
// Shared types and constants for the grid line cell walk: coordinate width,
// input and result payloads, controller/datapath command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package gcw_pkg;

  // Coordinate width of every input and result field
  localparam int unsigned COORD_BITS = 5;
  // Width of the doubled crossing terms (1 + 2*i) * n
  localparam int unsigned TERM_BITS  = 2 * COORD_BITS + 1;
  // Width of the remaining-step count, up to 2 * (2^COORD_BITS - 1)
  localparam int unsigned CNT_BITS   = COORD_BITS + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [TERM_BITS-1:0]  term_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  // Segment end points, one input transfer
  typedef struct packed {
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } item_t;

  // One visited cell, one result transfer
  typedef struct packed {
    coord_t cell_x;
    coord_t cell_y;
    logic   last_cell;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/gcw_datapath.sv
// ----------------------------------------------------------------------------
// gcw_datapath
// Cell position, incremental crossing terms and remaining-step count.
// The products (1+2*ix)*ny and (1+2*iy)*nx are kept as running sums.
// ----------------------------------------------------------------------------
`default_nettype none

module gcw_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire gcw_pkg::item_t     item,
  input  wire gcw_pkg::dp_cmd_t   cmd,
  output gcw_pkg::dp_status_t     status,
  output gcw_pkg::coord_t         cell_x,
  output gcw_pkg::coord_t         cell_y
);

  gcw_pkg::coord_t x, y;
  gcw_pkg::term_t  lhs, rhs;
  gcw_pkg::term_t  lhs_inc, rhs_inc;
  gcw_pkg::cnt_t   remaining;
  logic            x_up, y_up;

  gcw_pkg::coord_t nx, ny;
  logic            step_x;

  // Axis lengths of the incoming segment
  always_comb begin
    nx = (item.x_end >= item.x_start) ? (item.x_end - item.x_start)
                                      : (item.x_start - item.x_end);
    ny = (item.y_end >= item.y_start) ? (item.y_end - item.y_start)
                                      : (item.y_start - item.y_end);
  end

  // Earlier boundary crossing wins; a tie goes to y
  assign step_x = (lhs < rhs);

  // Walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x         <= item.x_start;
      y         <= item.y_start;
      x_up      <= item.x_end > item.x_start;
      y_up      <= item.y_end > item.y_start;
      lhs       <= gcw_pkg::term_t'(ny);
      rhs       <= gcw_pkg::term_t'(nx);
      lhs_inc   <= gcw_pkg::term_t'({ny, 1'b0});
      rhs_inc   <= gcw_pkg::term_t'({nx, 1'b0});
      remaining <= gcw_pkg::cnt_t'(nx) + gcw_pkg::cnt_t'(ny);
    end else if (cmd.step) begin
      if (step_x) begin
        x   <= x_up ? x + 1'b1 : x - 1'b1;
        lhs <= lhs + lhs_inc;
      end else begin
        y   <= y_up ? y + 1'b1 : y - 1'b1;
        rhs <= rhs + rhs_inc;
      end
      remaining <= remaining - 1'b1;
    end
  end

  assign status.last = (remaining == '0);
  assign cell_x      = x;
  assign cell_y      = y;

  // A step moves exactly one coordinate by one cell
  a_one_axis: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.step) && !$past(cmd.load) |->
      $countones({x != $past(x), y != $past(y)}) == 1)
    else $error("step moved both or neither axis");

  // The controller never steps past the final cell
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> remaining != '0)
    else $error("step issued with no steps remaining");

  // Load and step are exclusive
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.step))
    else $error("load and step together");

endmodule

`default_nettype wire

FILE: rtl/gcw_ctrl.sv
// ----------------------------------------------------------------------------
// gcw_ctrl
// Walk controller: idle/walk sequencing, start acceptance, result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module gcw_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire gcw_pkg::dp_status_t status,
  output gcw_pkg::dp_cmd_t         cmd,
  output logic                     busy,
  output logic                     strobe
);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t state;

  // Busy drops on the final cell so the next segment can follow at once
  assign strobe   = (state == S_WALK);
  assign busy     = strobe && !status.last;
  assign cmd.load = start && !busy;
  assign cmd.step = busy;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) state <= S_WALK;
        end
        S_WALK: begin
          if (status.last && !start) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The last cell without a new transfer returns to idle
  a_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) && status.last && !start |=> state == S_IDLE)
    else $error("walk did not end after last cell");

  // An accepted transfer always leads to a strobe next cycle
  a_load_strobe: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> strobe)
    else $error("no cell after accepted segment");

endmodule

`default_nettype wire

FILE: rtl/grid_line_cell_walk_core.sv
// ----------------------------------------------------------------------------
// grid_line_cell_walk_core
// Emits every grid cell crossed by a segment, one orthogonal step per cell.
// ----------------------------------------------------------------------------
// The first cell is shown in the cycle after the start transfer.
// Throughput: one cell per cycle from the single shared step/compare datapath;
//   a segment gives |dx| + |dy| + 1 cells, at most 63.
// busy falls during the final cell, so the next start is taken on that edge.
// Results cannot be stalled: each is valid for the one strobe cycle.
// Reset (rst, synchronous) returns the controller to idle, discarding a walk.
`default_nettype none

module grid_line_cell_walk_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire gcw_pkg::item_t   item,
  output logic                  busy,
  output logic                  strobe,
  output gcw_pkg::result_t      result
);

  gcw_pkg::dp_cmd_t    cmd;
  gcw_pkg::dp_status_t status;
  gcw_pkg::coord_t     cell_x, cell_y;

  gcw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  gcw_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .cell_x (cell_x),
    .cell_y (cell_y)
  );

  // Result assembly
  assign result.cell_x    = cell_x;
  assign result.cell_y    = cell_y;
  assign result.last_cell = status.last;

endmodule

`default_nettype wire

FILE: test/tb_grid_line_cell_walk_core.sv
// ----------------------------------------------------------------------------
// tb_grid_line_cell_walk_core
// Self-checking bench for the grid line cell walk. A queue of segments feeds a
// clocked driver that applies start/item on the falling edge, with random idle
// bursts and two drain pauses. A clocked monitor predicts the full cell walk of
// each accepted segment and checks every strobed cell in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_grid_line_cell_walk_core;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 70;
  localparam int unsigned RANDOM_SEGMENTS = 260;

  // Segment waiting to be sent, with its sending constraints
  typedef struct {
    gcw_pkg::item_t seg;
    bit             hold_off;  // wait until every due cell has arrived
    bit             calm;      // no idle burst before this one
  } pending_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  gcw_pkg::item_t   item = '0;
  logic             busy;
  logic             strobe;
  gcw_pkg::result_t result;

  pending_t         pending[$];
  gcw_pkg::result_t cells_due[$];
  bit               handed = 1'b0;
  int unsigned      gap_left = 0;
  int unsigned      cycles = 0;
  int unsigned      errors = 0;

  grid_line_cell_walk_core dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  always #5 clk = ~clk;

  // Walk the segment cell by cell; the step order follows the doubled
  // boundary-crossing compare, a tie going to y
  task automatic plan_walk(input gcw_pkg::item_t seg);
    int unsigned      run_x, run_y, done_x, done_y;
    bit               grow_x, grow_y;
    gcw_pkg::coord_t  px, py;
    gcw_pkg::result_t visit;
    run_x  = (seg.x_end >= seg.x_start) ? seg.x_end - seg.x_start : seg.x_start - seg.x_end;
    run_y  = (seg.y_end >= seg.y_start) ? seg.y_end - seg.y_start : seg.y_start - seg.y_end;
    grow_x = seg.x_end > seg.x_start;
    grow_y = seg.y_end > seg.y_start;
    px     = seg.x_start;
    py     = seg.y_start;
    done_x = 0;
    done_y = 0;
    visit.cell_x    = px;
    visit.cell_y    = py;
    visit.last_cell = (run_x == 0) && (run_y == 0);
    cells_due = {cells_due, visit};
    while (done_x < run_x || done_y < run_y) begin
      if ((1 + 2 * done_x) * run_y < (1 + 2 * done_y) * run_x) begin
        px = grow_x ? px + 1'b1 : px - 1'b1;
        done_x++;
      end else begin
        py = grow_y ? py + 1'b1 : py - 1'b1;
        done_y++;
      end
      visit.cell_x    = px;
      visit.cell_y    = py;
      visit.last_cell = (done_x >= run_x) && (done_y >= run_y);
      cells_due = {cells_due, visit};
    end
  endtask

  task automatic add_segment(input int xs, input int ys, input int xe, input int ye,
                             input bit hold_off, input bit calm);
    pending_t p;
    p.seg.x_start = gcw_pkg::coord_t'(xs);
    p.seg.y_start = gcw_pkg::coord_t'(ys);
    p.seg.x_end   = gcw_pkg::coord_t'(xe);
    p.seg.y_end   = gcw_pkg::coord_t'(ye);
    p.hold_off    = hold_off;
    p.calm        = calm;
    pending = {pending, p};
  endtask

  // Small random offset from a coordinate, kept on the grid
  function automatic int nudge(input int c);
    int n;
    n = c + int'($urandom_range(0, 6)) - 3;
    if (n < 0) n = 0;
    if (n > 31) n = 31;
    return n;
  endfunction

  // Driver: present the head of the queue, hold it until transferred
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      start    <= 1'b0;
    end else if (start && !handed) begin
      // still waiting for the transfer
    end else if (pending.size() == 0) begin
      start <= 1'b0;
    end else if (pending[0].hold_off && (cells_due.size() != 0 || busy)) begin
      start <= 1'b0;
    end else if (!pending[0].calm && $urandom_range(0, 4) == 0) begin
      gap_left <= $urandom_range(0, 8);
      start    <= 1'b0;
    end else begin
      start <= 1'b1;
      item  <= pending[0].seg;
    end
  end

  // Monitor: record transfers, check strobed cells, watch the cycle budget
  always @(posedge clk) begin
    gcw_pkg::result_t want;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_grid_line_cell_walk_core: errors");
      $finish;
    end else if (rst) begin
      handed <= 1'b0;
    end else begin
      handed <= start && !busy;
      if (start && !busy) begin
        plan_walk(item);
        void'(pending.pop_front());
      end
      if (strobe) begin
        if (cells_due.size() == 0) begin
          errors++;
          $display("%0t: cell with nothing due: got x=%0d y=%0d last=%0b",
                   $time, result.cell_x, result.cell_y, result.last_cell);
        end else begin
          want = cells_due.pop_front();
          if (result.cell_x !== want.cell_x) begin
            errors++;
            $display("%0t: cell_x expected %0d got %0d", $time, want.cell_x, result.cell_x);
          end
          if (result.cell_y !== want.cell_y) begin
            errors++;
            $display("%0t: cell_y expected %0d got %0d", $time, want.cell_y, result.cell_y);
          end
          if (result.last_cell !== want.last_cell) begin
            errors++;
            $display("%0t: last_cell expected %0b got %0b", $time, want.last_cell,
                     result.last_cell);
          end
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int xs, ys, xe, ye, mode;

    // Directed: zero length at both corners, axis-aligned both ways,
    // full diagonals, ties and shallow/steep slopes
    add_segment(0, 0, 0, 0, 1'b0, 1'b0);
    add_segment(31, 31, 31, 31, 1'b0, 1'b0);
    add_segment(0, 7, 31, 7, 1'b0, 1'b0);
    add_segment(31, 20, 0, 20, 1'b0, 1'b0);
    add_segment(12, 0, 12, 31, 1'b0, 1'b0);
    add_segment(3, 31, 3, 0, 1'b0, 1'b0);
    add_segment(0, 0, 31, 31, 1'b0, 1'b0);
    add_segment(31, 31, 0, 0, 1'b0, 1'b0);
    add_segment(0, 31, 31, 0, 1'b0, 1'b0);
    add_segment(31, 0, 0, 31, 1'b0, 1'b0);
    add_segment(0, 0, 1, 1, 1'b0, 1'b0);
    add_segment(10, 10, 13, 7, 1'b0, 1'b0);
    add_segment(0, 0, 3, 1, 1'b0, 1'b0);
    add_segment(5, 5, 6, 20, 1'b0, 1'b0);
    add_segment(31, 0, 0, 1, 1'b0, 1'b0);
    add_segment(0, 30, 1, 0, 1'b0, 1'b0);
    add_segment(21, 10, 10, 21, 1'b0, 1'b0);
    add_segment(16, 15, 15, 16, 1'b0, 1'b0);

    // Random: some degenerate, some axis-aligned, some short, the rest anywhere on the grid
    for (int i = 0; i < RANDOM_SEGMENTS; i++) begin
      mode = $urandom_range(0, 9);
      xs = $urandom_range(0, 31);
      ys = $urandom_range(0, 31);
      xe = $urandom_range(0, 31);
      ye = $urandom_range(0, 31);
      case (mode)
        0: begin
          xe = xs;
          ye = ys;
        end
        1: ye = ys;
        2: xe = xs;
        3, 4, 5: begin
          xe = nudge(xs);
          ye = nudge(ys);
        end
        default: ;
      endcase
      add_segment(xs, ys, xe, ye, (i == 0) || (i == RANDOM_SEGMENTS / 2),
                  i >= RANDOM_SEGMENTS - 40);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || cells_due.size() != 0 || start) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("tb_grid_line_cell_walk_core: clean");
    end else begin
      $display("tb_grid_line_cell_walk_core: errors");
    end
    $finish;
  end

endmodule

FILE: grid_line_cell_walk_core.f
rtl/gcw_pkg.sv
rtl/gcw_datapath.sv
rtl/gcw_ctrl.sv
rtl/grid_line_cell_walk_core.sv
test/tb_grid_line_cell_walk_core.sv
